// ----- sv/hlsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// hlsfr_pkg: shared types and constants of the frame receiver
// Marker bytes, the received-byte type and the result record.
// ----------------------------------------------------------------------------
package hlsfr_pkg;

   localparam logic [7:0] HDR_BYTE    = 8'hA5;
   localparam logic [7:0] SYNC_BYTE   = 8'h5A;
   localparam logic [7:0] HEADING_CMD = 8'hA6;
   localparam logic [7:0] MIN_LENGTH  = 8'd2;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic        checksum_ok;
      byte_type    command;
      logic        heading_updated;
      logic [15:0] target_heading;
   } result_type;

endpackage

// ----- sv/hlsfr_if.sv -----
// ----------------------------------------------------------------------------
// hlsfr_if: valid/ready channels of the frame receiver
// Byte request channel and frame result channel.
// ----------------------------------------------------------------------------
interface hlsfr_req_if;
   import hlsfr_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlsfr_rsp_if;
   import hlsfr_pkg::*;

   logic        valid;
   logic        ready;
   logic        checksum_ok;
   byte_type    command;
   logic        heading_updated;
   logic [15:0] target_heading;

   modport source (output valid, output checksum_ok, output command,
                   output heading_updated, output target_heading, input ready);
   modport sink   (input valid, input checksum_ok, input command,
                   input heading_updated, input target_heading, output ready);
endinterface

// ----- sv/hlsfr_core.sv -----
// ----------------------------------------------------------------------------
// hlsfr_core: frame state and checksum evaluation
// Tracks the write index, the first four stored bytes and a running sum.
// ----------------------------------------------------------------------------
module hlsfr_core #(
   parameter int BUFFER_SIZE = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  hlsfr_pkg::byte_type  rx_byte,
   output logic                 done,
   output hlsfr_pkg::result_type result
);
   import hlsfr_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_SIZE - 1);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             header_ff, header_in;
   byte_type         head_ff [4];
   byte_type         head_in [4];
   byte_type         acc_ff, acc_in;     // sum of bytes 0 .. idx-2
   byte_type         prev_ff, prev_in;   // byte at idx-1
   logic [15:0]      heading_ff, heading_in;

   logic             is_hdr, is_sync, restart, advance, ok, upd;
   logic [IDX_W:0]   idx_plus;
   byte_type         len;

   always_comb begin
      is_hdr   = (rx_byte == HDR_BYTE);
      is_sync  = (rx_byte == SYNC_BYTE);
      restart  = is_sync && header_ff;
      advance  = (idx_ff != LAST_IDX);
      idx_plus = {1'b0, idx_ff} + 1'b1;

      // the first four entries are kept in flops for length, command, heading
      for (int k = 0; k < 4; k++) begin
         head_in[k] = (!restart && idx_ff == IDX_W'(k)) ? rx_byte : head_ff[k];
      end
      len = head_in[0];

      done = !is_hdr && !is_sync && (9'(idx_plus) == {1'b0, len});
      ok   = (len >= MIN_LENGTH) && (acc_ff == prev_ff);
      upd  = ok && (head_in[1] == HEADING_CMD);
      heading_in = upd ? {head_in[2], head_in[3]} : heading_ff;

      header_in = is_hdr;
      if (restart || done) begin
         idx_in  = '0;
         acc_in  = '0;
         prev_in = '0;
      end else if (advance) begin
         idx_in  = idx_plus[IDX_W-1:0];
         acc_in  = acc_ff + prev_ff;
         prev_in = rx_byte;
      end else begin
         // hold at the last entry; earlier entries stay untouched
         idx_in  = idx_ff;
         acc_in  = acc_ff;
         prev_in = prev_ff;
      end

      result.checksum_ok     = ok;
      result.command         = head_in[1];
      result.heading_updated = upd;
      result.target_heading  = heading_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         header_ff  <= 1'b0;
         acc_ff     <= '0;
         prev_ff    <= '0;
         heading_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            head_ff[k] <= '0;
         end
      end else if (step) begin
         idx_ff     <= idx_in;
         header_ff  <= header_in;
         acc_ff     <= acc_in;
         prev_ff    <= prev_in;
         heading_ff <= (done ? heading_in : heading_ff);
         for (int k = 0; k < 4; k++) begin
            head_ff[k] <= head_in[k];
         end
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("write index beyond buffer end");

   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      step && done |=> idx_ff == '0 && acc_ff == '0)
      else $error("completed frame did not restart index and sum");

   a_heading_hold: assert property (@(posedge clock) disable iff (reset)
      step && !(done && upd) |=> heading_ff == $past(heading_ff))
      else $error("heading changed without a passing heading frame");

endmodule

// ----- sv/hlsfr_out_reg.sv -----
// ----------------------------------------------------------------------------
// hlsfr_out_reg: result output register
// Holds one frame result until the sink takes it.
// ----------------------------------------------------------------------------
module hlsfr_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hlsfr_pkg::result_type data,
   output logic                  free,
   hlsfr_rsp_if.source           rsp_ch
);
   import hlsfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   always_comb begin
      free = !valid_ff || rsp_ch.ready;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.checksum_ok     = data_ff.checksum_ok;
   assign rsp_ch.command         = data_ff.command;
   assign rsp_ch.heading_updated = data_ff.heading_updated;
   assign rsp_ch.target_heading  = data_ff.target_heading;

endmodule

// ----- sv/header_length_sum_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// header_length_sum_frame_receiver: length-prefixed serial frame receiver
// Takes one received byte per transfer and reports each completed frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one received serial byte per transfer (valid/ready).
//   rsp_ch carries one result per completed frame: checksum_ok, command
//   (frame byte 1), heading_updated and the current target heading.
//   Bytes that do not complete a frame produce no transfer on rsp_ch.
// Timing: a taken byte sits in the input register, is evaluated by the core
//   and, if it completes a frame, its result is registered and shown on rsp_ch.
// Throughput: one byte per cycle unless stalled. The checksum is a running sum
//   updated as each byte is stored, so the frame check is a single compare
//   at the completing byte; the input-to-result-register path sets this.
// Reset: synchronous, active high. Clears the write index, the header flag,
//   the running sum, the stored length/command/heading bytes and the heading.
// Stall: a full result register whose transfer is not taken holds only a
//   byte that would complete a frame; other bytes keep flowing, and req_ch
//   backs up once the input register holds a completing byte.
// ----------------------------------------------------------------------------
module header_length_sum_frame_receiver #(
   parameter int BUFFER_SIZE = 128
) (
   input  logic        clock,
   input  logic        reset,
   hlsfr_req_if.sink   req_ch,
   hlsfr_rsp_if.source rsp_ch
);
   import hlsfr_pkg::*;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   byte_type   s1_byte_ff;

   logic       core_done;
   result_type core_result;
   logic       out_free;
   logic       s1_go;
   logic       step;
   logic       req_fire;

   // advance the held byte unless it completes a frame and the result
   // register is still occupied
   always_comb begin
      s1_go        = !core_done || out_free;
      step         = s1_valid_ff && s1_go;
      req_ch.ready = !s1_valid_ff || s1_go;
      req_fire     = req_ch.valid && req_ch.ready;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_ch.rx_byte;
      end
   end

   // frame tracking and checksum compare
   hlsfr_core #(
      .BUFFER_SIZE (BUFFER_SIZE)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (s1_byte_ff),
      .done    (core_done),
      .result  (core_result)
   );

   // load the result register only on the completing byte
   hlsfr_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (step && core_done),
      .data   (core_result),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- test/frame_check_pkg.sv -----
// ----------------------------------------------------------------------------
// frame_check_pkg: scoreboard for the frame receiver bench
// Tracks the receiver's byte store, write index, header flag and heading, and
// keeps the frame reports that completed frames must produce, oldest first.
// ----------------------------------------------------------------------------
package frame_check_pkg;
   import hlsfr_pkg::*;

   localparam int STORE_DEPTH = 128;

   class frame_scoreboard;
      byte_type    store_mem [STORE_DEPTH];
      int unsigned wr_idx;
      bit          hdr_seen;
      logic [15:0] heading;
      result_type  frame_reports [$];
      int          errors;

      function new();
         foreach (store_mem[i]) store_mem[i] = '0;
         wr_idx   = 0;
         hdr_seen = 0;
         heading  = '0;
         errors   = 0;
      endfunction

      function byte_type byte_at(int unsigned pos);
         return (pos < STORE_DEPTH) ? store_mem[pos] : byte_type'(0);
      endfunction

      function void put_byte(byte_type b);
         if (wr_idx < STORE_DEPTH) store_mem[wr_idx] = b;
         wr_idx++;
      endfunction

      // 8-bit sum of bytes 0..len-3 against byte len-2; short lengths fail
      function bit sum_matches();
         int unsigned len;
         byte_type    total;
         len   = store_mem[0];
         total = '0;
         if (len < MIN_LENGTH) return 0;
         for (int unsigned i = 0; i + 2 < len; i++) total += byte_at(i);
         return total == byte_at(len - 2);
      endfunction

      // Advance the store by one accepted byte; queue a report on completion
      function void note_byte(byte_type b);
         bit         done;
         result_type rep;
         done = 0;
         if (b == HDR_BYTE) begin
            hdr_seen = 1;
            put_byte(b);
         end else if (b == SYNC_BYTE) begin
            if (hdr_seen) wr_idx = 0;
            else put_byte(b);
            hdr_seen = 0;
         end else begin
            put_byte(b);
            hdr_seen = 0;
            if (wr_idx == store_mem[0]) begin
               wr_idx = 0;
               done   = 1;
            end
         end
         if (wr_idx >= STORE_DEPTH) wr_idx = STORE_DEPTH - 1;
         if (done) begin
            rep.checksum_ok     = sum_matches();
            rep.command         = byte_at(1);
            rep.heading_updated = rep.checksum_ok && (rep.command == HEADING_CMD);
            if (rep.heading_updated) heading = {byte_at(2), byte_at(3)};
            rep.target_heading  = heading;
            frame_reports.push_back(rep);
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (frame_reports.size() == 0) begin
            $display("%0t: unexpected frame report, ok %0b command %0h updated %0b heading %0h",
                     $time, got.checksum_ok, got.command, got.heading_updated,
                     got.target_heading);
            errors++;
            return;
         end
         want = frame_reports.pop_front();
         compare_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
         compare_field("command", 16'(want.command), 16'(got.command));
         compare_field("heading_updated", 16'(want.heading_updated),
                       16'(got.heading_updated));
         compare_field("target_heading", want.target_heading, got.target_heading);
      endfunction

      function int pending();
         return frame_reports.size();
      endfunction
   endclass

endpackage

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: bench for header_length_sum_frame_receiver
// Feeds received bytes as directed cases and then as random frames, broken
// frames and noise, with random gaps and stalls on both channels, and checks
// every frame report against a scoreboard that tracks the receiver's state.
// ----------------------------------------------------------------------------
module tb_top;
   import hlsfr_pkg::*;
   import frame_check_pkg::*;

   localparam int ITEM_TARGET    = 750;
   localparam int MAX_GAP        = 10;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT_ITEM   = 350;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hlsfr_req_if req_ch ();
   hlsfr_rsp_if rsp_ch ();

   header_length_sum_frame_receiver #(
      .BUFFER_SIZE(STORE_DEPTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   frame_scoreboard sb = new();

   int         items_sent    = 0;
   int         idle_cycles   = 0;
   bit         sender_calm   = 0;
   bit         receiver_calm = 0;
   bit         hold_request  = 0;
   result_type frame_result;

   assign frame_result = {rsp_ch.checksum_ok, rsp_ch.command,
                          rsp_ch.heading_updated, rsp_ch.target_heading};

   always #2 clock = ~clock;

   // A calm side never idles; otherwise it draws a random gap of 0..MAX_GAP per transfer
   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Frame content that cannot be mistaken for a header or sync byte
   function automatic byte_type rand_data();
      byte_type b;
      do b = byte_type'($urandom_range(0, 255));
      while (b == HDR_BYTE || b == SYNC_BYTE);
      return b;
   endfunction

   // Mostly short frames; now and then a long one, one that fills the store
   // exactly, or one longer than the store that never completes.
   function automatic int random_length();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 1) return STORE_DEPTH;
      if (pick < 2) return $urandom_range(STORE_DEPTH + 1, 160);
      if (pick < 5) begin
         do len = $urandom_range(17, STORE_DEPTH - 1);
         while (len == SYNC_BYTE);
         return len;
      end
      return $urandom_range(1, 16);
   endfunction

   // Offer one byte from a falling edge and hold it until the transfer.
   // Returns at the falling edge after the transfer.
   task automatic send_byte(byte_type b);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      gap = draw_gap(sender_calm);
      if (items_sent == HOLD_AT_ITEM) hold_request = 1;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock);
      while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Build a frame of the given length: length byte, command, heading bytes,
   // sum byte at len-2 for lengths 3..STORE_DEPTH (right or corrupted), then send the first count bytes.
   task automatic send_frame(int len, byte_type cmd, byte_type hi, byte_type lo,
                             bit good_sum, bit with_header, int count);
      byte_type frame [$];
      byte_type total;
      frame.push_back(byte_type'(len));
      for (int i = 1; i < len; i++) frame.push_back(rand_data());
      if (len >= 2) frame[1] = cmd;
      if (len >= 4) begin
         frame[2] = hi;
         frame[3] = lo;
      end
      if (len >= 3 && len <= STORE_DEPTH) begin
         total = '0;
         for (int i = 0; i < len - 2; i++) total += frame[i];
         frame[len - 2] = good_sum ? total : total + byte_type'($urandom_range(1, 255));
      end
      if (with_header) begin
         send_byte(HDR_BYTE);
         send_byte(SYNC_BYTE);
      end
      for (int i = 0; i < count && i < len; i++) send_byte(frame[i]);
   endtask

   // Raw bytes, header and sync values included
   task automatic send_noise(int n);
      repeat (n) send_byte(byte_type'($urandom_range(0, 255)));
   endtask

   // Result side: draw a stall per report, once take the long hold-off so the
   // result register stays full and the byte channel backs up behind it.
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
         if (hold_request) begin
            n            = HOLD_CYCLES;
            hold_request = 0;
         end else begin
            n = draw_gap(receiver_calm);
         end
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock);
         while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Monitor: check reports before noting bytes, since a byte taken at this
   // edge cannot have produced a report at the same edge. The watchdog counts
   // edges with no transfer on either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(frame_result);
         if (req_ch.valid && req_ch.ready) sb.note_byte(req_ch.rx_byte);
      end
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int       len;
      int       pick;
      byte_type cmd;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Length one straight after reset: fails, command from the cleared store
      send_byte(8'h01);
      // Stray sync with no header is stored, then a header pair restarts
      send_byte(SYNC_BYTE);
      send_byte(HDR_BYTE);
      send_byte(SYNC_BYTE);
      // Length zero: these bytes never complete a frame
      send_byte(8'h00);
      send_byte(8'h33);
      // Heading update to all ones after a restart
      send_frame(6, HEADING_CMD, 8'hFF, 8'hFF, 1, 1, 6);
      // Back-to-back frame with no header, heading to all zeros
      send_frame(6, HEADING_CMD, 8'h00, 8'h00, 1, 0, 6);
      // Double header then sync restarts; a length of two always fails
      send_byte(HDR_BYTE);
      send_byte(HDR_BYTE);
      send_byte(SYNC_BYTE);
      send_frame(2, HEADING_CMD, 8'h00, 8'h00, 1, 0, 2);

      // Random part: mostly whole frames with random content, some cut short,
      // some noise between them.
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         len  = random_length();
         cmd  = $urandom_range(0, 1) ? HEADING_CMD : rand_data();
         if (pick < 70) begin
            send_frame(len, cmd, rand_data(), rand_data(), $urandom_range(0, 4) != 0,
                       $urandom_range(0, 4) != 0, len);
         end else if (pick < 85) begin
            send_frame(len, cmd, rand_data(), rand_data(), 1, 1, $urandom_range(0, len - 1));
         end else begin
            send_noise($urandom_range(1, 8));
         end
      end
      req_ch.valid <= 1'b0;

      // Drain: wait for every report, then keep watching for strays before the verdict
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/hlsfr_pkg.sv
sv/hlsfr_if.sv
sv/hlsfr_core.sv
sv/hlsfr_out_reg.sv
sv/header_length_sum_frame_receiver.sv
test/frame_check_pkg.sv
test/tb_top.sv
